FILE: rtl/jpts_pkg.sv
// ----------------------------------------------------------------------------
// Joint PD torque servo package
// Shared widths, opcodes, register map, configuration and control types.
// ----------------------------------------------------------------------------
package jpts_pkg;

  // Fractional bits of every Q12.20-style quantity (angles, speeds, gains).
  localparam int ANGLE_FRAC_BITS = 20;

  localparam int MOTOR_ID_W = 11;
  localparam int GEAR_W     = 20;
  localparam int CSCALE_W   = 16;
  localparam int ANGLE_W    = 32;
  localparam int PAYLOAD_W  = 64;
  localparam int CUR_CMD_W  = 13;
  localparam int MCUR_W     = 16;

  localparam logic [7:0] OP_SPEED  = 8'h9C;
  localparam logic [7:0] OP_POS    = 8'h92;
  localparam logic [7:0] OP_TORQUE = 8'hA1;

  // Serial multiplier: radix-4, two multiplier bits retired per cycle.
  localparam int MUL_A_W   = 64;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_STEPS = MUL_B_W / 2;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // pi/180 in Q0.32 and pi/18000 in Q0.40.
  localparam logic [MUL_B_W-1:0] DEG_RAD_Q32  = 32'd74961321;
  localparam logic [MUL_B_W-1:0] CDEG_RAD_Q40 = 32'd191900981;

  localparam int SPEED_SHIFT = 48 - ANGLE_FRAC_BITS;
  localparam int POS_SHIFT   = 56 - ANGLE_FRAC_BITS;
  localparam int CUR_SHIFT   = ANGLE_FRAC_BITS + 8;

  // Position magnitude is clamped to 2^41 before scaling.
  localparam int POS_RAW_W = 56;
  localparam int POS_MAG_W = 42;
  localparam logic [POS_RAW_W-1:0] POS_CLAMP = POS_RAW_W'(1) << (POS_MAG_W - 1);

  // Converted magnitudes are clamped to 2^33, enough for the 32-bit saturation.
  localparam int VMAG_W = 34;
  localparam int SV_W   = VMAG_W + 2;

  // Control term and torque sum widths follow from the fraction bits.
  localparam int TERM_W = 66 - ANGLE_FRAC_BITS;
  localparam int TAU_W  = 69 - ANGLE_FRAC_BITS;

  localparam int CUR_MAG_W = 12;
  localparam logic [CUR_MAG_W-1:0] CUR_LIMIT = 12'd2048;

  // Register map, one 32-bit register every four bytes.
  localparam int CFG_REG_COUNT = 7;
  localparam int CFG_ADDR_W    = $clog2(CFG_REG_COUNT * 4);
  localparam int CFG_IDX_W     = CFG_ADDR_W - 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_RECIP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_SCALE   = 3'd6;

  localparam logic [MOTOR_ID_W-1:0] MOTOR_ID_RST  = 11'h141;
  localparam logic [GEAR_W-1:0]     GEAR_RST      = 20'd65536;
  localparam logic [CSCALE_W-1:0]   CSCALE_RST    = 16'd15888;
  localparam logic [ANGLE_W-1:0]    ANGLE_MIN_RST = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0]    ANGLE_MAX_RST = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [MOTOR_ID_W-1:0]     motor_id;
    logic                      direction;
    logic signed [ANGLE_W-1:0] zero_offset;
    logic signed [ANGLE_W-1:0] angle_min;
    logic signed [ANGLE_W-1:0] angle_max;
    logic [GEAR_W-1:0]         gear_recip;
    logic [CSCALE_W-1:0]       current_scale;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL1,
    ST_ARM2,
    ST_MUL2,
    ST_FINISH,
    ST_SUM,
    ST_ARM3,
    ST_MUL3,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    JOB_SPEED,
    JOB_POS,
    JOB_TICK,
    JOB_NONE
  } job_t;

endpackage

FILE: rtl/jpts_in_if.sv
// ----------------------------------------------------------------------------
// Joint PD torque servo input channel
// Valid/ready channel carrying one received frame or control tick per word.
// ----------------------------------------------------------------------------
interface jpts_in_if;
  import jpts_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [MOTOR_ID_W-1:0]       rx_id;
  logic [PAYLOAD_W-1:0]        rx_payload;
  logic signed [ANGLE_W-1:0]   torque_ff;
  logic [ANGLE_W-1:0]          gain_p;
  logic [ANGLE_W-1:0]          gain_d;
  logic signed [ANGLE_W-1:0]   angle_target;
  logic signed [ANGLE_W-1:0]   speed_target;

  modport source (
    output valid, command, rx_id, rx_payload, torque_ff, gain_p, gain_d,
           angle_target, speed_target,
    input  ready
  );

  modport sink (
    input  valid, command, rx_id, rx_payload, torque_ff, gain_p, gain_d,
           angle_target, speed_target,
    output ready
  );

endinterface

FILE: rtl/jpts_out_if.sv
// ----------------------------------------------------------------------------
// Joint PD torque servo output channel
// Valid/ready channel carrying one torque frame and status per word.
// ----------------------------------------------------------------------------
interface jpts_out_if;
  import jpts_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [MOTOR_ID_W-1:0]       tx_id;
  logic [PAYLOAD_W-1:0]        tx_payload;
  logic signed [CUR_CMD_W-1:0] current_command;
  logic                        limit_fault;
  logic signed [ANGLE_W-1:0]   angle_now;
  logic signed [MCUR_W-1:0]    measured_current;

  modport source (
    output valid, tx_id, tx_payload, current_command, limit_fault, angle_now,
           measured_current,
    input  ready
  );

  modport sink (
    input  valid, tx_id, tx_payload, current_command, limit_fault, angle_now,
           measured_current,
    output ready
  );

endinterface

FILE: rtl/jpts_regs.sv
// ----------------------------------------------------------------------------
// Joint PD torque servo configuration registers
// APB-style register file holding the motor identifier, limits and scales.
// ----------------------------------------------------------------------------
module jpts_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jpts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jpts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jpts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output jpts_pkg::cfg_t                cfg_o
);
  import jpts_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign cfg_o  = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_id      <= MOTOR_ID_RST;
      cfg_r.direction     <= 1'b0;
      cfg_r.zero_offset   <= '0;
      cfg_r.angle_min     <= ANGLE_MIN_RST;
      cfg_r.angle_max     <= ANGLE_MAX_RST;
      cfg_r.gear_recip    <= GEAR_RST;
      cfg_r.current_scale <= CSCALE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MOTOR_ID:    cfg_r.motor_id      <= pwdata[MOTOR_ID_W-1:0];
        REG_DIRECTION:   cfg_r.direction     <= pwdata[0];
        REG_ZERO_OFFSET: cfg_r.zero_offset   <= pwdata[ANGLE_W-1:0];
        REG_ANGLE_MIN:   cfg_r.angle_min     <= pwdata[ANGLE_W-1:0];
        REG_ANGLE_MAX:   cfg_r.angle_max     <= pwdata[ANGLE_W-1:0];
        REG_GEAR_RECIP:  cfg_r.gear_recip    <= pwdata[GEAR_W-1:0];
        REG_CUR_SCALE:   cfg_r.current_scale <= pwdata[CSCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MOTOR_ID:    prdata = CFG_DATA_W'(cfg_r.motor_id);
      REG_DIRECTION:   prdata = CFG_DATA_W'(cfg_r.direction);
      REG_ZERO_OFFSET: prdata = CFG_DATA_W'(unsigned'(cfg_r.zero_offset));
      REG_ANGLE_MIN:   prdata = CFG_DATA_W'(unsigned'(cfg_r.angle_min));
      REG_ANGLE_MAX:   prdata = CFG_DATA_W'(unsigned'(cfg_r.angle_max));
      REG_GEAR_RECIP:  prdata = CFG_DATA_W'(cfg_r.gear_recip);
      REG_CUR_SCALE:   prdata = CFG_DATA_W'(cfg_r.current_scale);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/jpts_smul.sv
// ----------------------------------------------------------------------------
// Joint PD torque servo serial multiplier
// Radix-4 shift-add multiplier retiring two multiplier bits per cycle.
// ----------------------------------------------------------------------------
module jpts_smul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [jpts_pkg::MUL_A_W-1:0]  a_i,
  input  logic [jpts_pkg::MUL_B_W-1:0]  b_i,
  output jpts_pkg::mul_sts_t            sts_o,
  output logic [jpts_pkg::MUL_P_W-1:0]  prod_o
);
  import jpts_pkg::*;

  logic [MUL_A_W-1:0]   a_r;
  logic [MUL_A_W+1:0]   a3_r;
  logic [MUL_A_W-1:0]   acc_r;
  logic [MUL_B_W-1:0]   b_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [MUL_A_W+1:0]   addend;
  logic [MUL_A_W+1:0]   sum;

  // The multiplier register doubles as the low half of the product: as each
  // digit is consumed, two finished product bits drop into its top.
  always_comb begin
    case (b_r[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, a_r};
      2'd2:    addend = {1'b0, a_r, 1'b0};
      default: addend = a3_r;
    endcase
    sum = {2'b00, acc_r} + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CNT_W'(MUL_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - MUL_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      a_r   <= a_i;
      a3_r  <= {1'b0, a_i, 1'b0} + {2'b00, a_i};
      acc_r <= '0;
      b_r   <= b_i;
    end else if (busy_r) begin
      acc_r <= sum[MUL_A_W+1:2];
      b_r   <= {sum[1:0], b_r[MUL_B_W-1:2]};
    end
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;
  assign prod_o     = {acc_r, b_r};

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("multiplier finished without running");

endmodule

FILE: rtl/joint_pd_torque_servo_top.sv
// ----------------------------------------------------------------------------
// Joint PD torque servo
// Decodes motor reply frames into joint state and turns control ticks into
// saturated 0xA1 torque frames for one motor.
// ----------------------------------------------------------------------------
// Usage. Words arrive on in_ch (valid/ready). A word with command 0 is a
// received reply frame: if its identifier equals motor_id, a 0x9C reply
// updates the stored speed and current and a 0x92 reply updates the stored
// angle; it produces no output word. A word with command 1 is a control tick:
// it produces exactly one word on out_ch holding the torque frame, the
// saturated current, the limit flag and the stored angle and current.
// Throughput. One word is handled at a time. Every product goes through the
// shared radix-4 serial multiplier. A frame that is not for this motor needs
// no product, a speed or position reply two and a tick three. A tick ends
// with its result registered on out_ch; the next word is taken only once the
// sequencer is back in idle.
// Stalls. The result sits in an output register, so in_ch takes the next word
// while an earlier result waits; a tick that finishes while out_ch is still
// stalled holds in its final state until the register frees.
// Reset. rst_n (synchronous, active low) zeroes the joint state, restores the
// register defaults and empties the output register. Configuration is to be
// written via the APB-style port while the block idles; this is not enforced.
// ----------------------------------------------------------------------------
module joint_pd_torque_servo_top (
  input  logic                            clk,
  input  logic                            rst_n,
  jpts_in_if.sink                         in_ch,
  jpts_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jpts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jpts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jpts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import jpts_pkg::*;

  localparam logic [MUL_P_W-1:0] VMAG_CAP = MUL_P_W'(1) << (VMAG_W - 1);
  localparam logic signed [SV_W-1:0] SAT_MAX = SV_W'(32'sh7FFF_FFFF);
  localparam logic signed [SV_W-1:0] SAT_MIN = -SV_W'(33'sh0_8000_0000);
  localparam logic signed [ANGLE_W-1:0] A_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ANGLE_W-1:0] A_MIN = 32'sh8000_0000;

  // Rounds half up while dropping sh bits: adding half and shifting is the
  // same as shifting and adding the last bit dropped.
  function automatic logic [MUL_P_W-1:0] round_shift(input logic [MUL_P_W-1:0] p,
                                                     input int sh);
    logic [MUL_P_W-1:0] q;
    q = p >> sh;
    return q + MUL_P_W'(p[sh-1]);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [SV_W-1:0] d);
    logic signed [ANGLE_W-1:0] r;
    if (d > SAT_MAX) begin
      r = A_MAX;
    end else if (d < SAT_MIN) begin
      r = A_MIN;
    end else begin
      r = d[ANGLE_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers and the shared multiplier.
  // ---------------------------------------------------------------------------
  cfg_t cfg;

  jpts_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  mul_sts_t           mul_sts;
  logic [MUL_P_W-1:0] mul_prod;

  jpts_smul u_smul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sts_o   (mul_sts),
    .prod_o  (mul_prod)
  );

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;
  job_t   job_r, job_sel;

  logic                        cap_cmd_r;
  logic [MOTOR_ID_W-1:0]       cap_id_r;
  logic [PAYLOAD_W-1:0]        cap_pl_r;
  logic signed [ANGLE_W-1:0]   cap_ff_r;
  logic [ANGLE_W-1:0]          cap_gp_r;
  logic [ANGLE_W-1:0]          cap_gd_r;
  logic signed [ANGLE_W-1:0]   cap_at_r;
  logic signed [ANGLE_W-1:0]   cap_st_r;

  logic signed [ANGLE_W-1:0]   joint_angle_r;
  logic signed [ANGLE_W-1:0]   joint_speed_r;
  logic signed [MCUR_W-1:0]    rep_cur_r;

  logic [MUL_A_W-1:0]          p1_r;
  logic signed [SV_W-1:0]      sv_r;
  logic signed [TAU_W-1:0]     tau_r;
  logic signed [TAU_W-1:0]     term_r;
  logic signed [CUR_CMD_W-1:0] cur_r;

  logic                        out_valid_r;
  logic [MOTOR_ID_W-1:0]       tx_id_r;
  logic [PAYLOAD_W-1:0]        tx_payload_r;
  logic signed [CUR_CMD_W-1:0] cur_cmd_r;
  logic                        fault_r;
  logic signed [ANGLE_W-1:0]   angle_now_r;
  logic signed [MCUR_W-1:0]    meas_cur_r;

  logic in_ready;
  logic in_take;
  logic out_load;

  // ---------------------------------------------------------------------------
  // Decode of the captured word.
  // ---------------------------------------------------------------------------
  logic                  id_hit;
  logic                  spd_neg;
  logic [15:0]           spd_mag;
  logic [POS_RAW_W-1:0]  pos_raw;
  logic                  pos_neg;
  logic [POS_RAW_W-1:0]  pos_abs;
  logic [POS_MAG_W-1:0]  pos_mag;
  logic [ANGLE_W:0]      err_a;
  logic [ANGLE_W:0]      err_d;
  logic                  err_a_neg;
  logic                  err_d_neg;
  logic [ANGLE_W:0]      err_a_mag;
  logic [ANGLE_W:0]      err_d_mag;

  always_comb begin
    id_hit    = (cap_id_r == cfg.motor_id);
    spd_neg   = cap_pl_r[47];
    spd_mag   = spd_neg ? (~cap_pl_r[47:32] + 16'd1) : cap_pl_r[47:32];
    pos_raw   = cap_pl_r[63:8];
    pos_neg   = pos_raw[POS_RAW_W-1];
    pos_abs   = pos_neg ? (~pos_raw + POS_RAW_W'(1)) : pos_raw;
    pos_mag   = (pos_abs > POS_CLAMP) ? POS_CLAMP[POS_MAG_W-1:0] : pos_abs[POS_MAG_W-1:0];
    // Errors are formed one bit wider so that the difference never wraps.
    err_a     = {cap_at_r[ANGLE_W-1], cap_at_r} - {joint_angle_r[ANGLE_W-1], joint_angle_r};
    err_d     = {cap_st_r[ANGLE_W-1], cap_st_r} - {joint_speed_r[ANGLE_W-1], joint_speed_r};
    err_a_neg = err_a[ANGLE_W];
    err_d_neg = err_d[ANGLE_W];
    err_a_mag = err_a_neg ? (~err_a + (ANGLE_W+1)'(1)) : err_a;
    err_d_mag = err_d_neg ? (~err_d + (ANGLE_W+1)'(1)) : err_d;

    if (cap_cmd_r) begin
      job_sel = JOB_TICK;
    end else if (id_hit && (cap_pl_r[7:0] == OP_SPEED)) begin
      job_sel = JOB_SPEED;
    end else if (id_hit && (cap_pl_r[7:0] == OP_POS)) begin
      job_sel = JOB_POS;
    end else begin
      job_sel = JOB_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Post-processing of multiplier results.
  // ---------------------------------------------------------------------------
  logic [MUL_P_W-1:0]          rnd_speed;
  logic [MUL_P_W-1:0]          rnd_pos;
  logic [MUL_P_W-1:0]          rnd_term;
  logic [MUL_P_W-1:0]          rnd_sel;
  logic [VMAG_W-1:0]           vmag;
  logic                        v_neg;
  logic signed [SV_W-1:0]      sv_nxt;
  logic signed [TAU_W-1:0]     term_ext;
  logic signed [TAU_W-1:0]     term_s_a;
  logic signed [TAU_W-1:0]     term_s_d;
  logic signed [TAU_W-1:0]     tau_sum;
  logic signed [TAU_W-1:0]     tau_dir;
  logic                        tau_neg;
  logic [TAU_W-1:0]            tau_abs;
  logic [MUL_P_W-1:0]          cm_full;
  logic [CUR_MAG_W-1:0]        cm;
  logic signed [CUR_CMD_W-1:0] cur_nxt;
  logic signed [SV_W-1:0]      fin_d;
  logic signed [ANGLE_W-1:0]   fin_x;
  logic signed [ANGLE_W-1:0]   fin_y;
  logic                        fault_nxt;

  always_comb begin
    rnd_speed = round_shift(mul_prod, SPEED_SHIFT);
    rnd_pos   = round_shift(mul_prod, POS_SHIFT);
    rnd_term  = round_shift(mul_prod, ANGLE_FRAC_BITS);

    // Converted angle or speed: clamp the magnitude, then attach its sign.
    rnd_sel = (job_r == JOB_SPEED) ? rnd_speed : rnd_pos;
    vmag    = (rnd_sel > VMAG_CAP) ? VMAG_CAP[VMAG_W-1:0] : rnd_sel[VMAG_W-1:0];
    v_neg   = (job_r == JOB_SPEED) ? spd_neg : pos_neg;
    sv_nxt  = v_neg ? -signed'(SV_W'(vmag)) : signed'(SV_W'(vmag));

    // Control terms carry the sign of their error.
    term_ext = signed'(TAU_W'(rnd_term[TERM_W-1:0]));
    term_s_a = err_a_neg ? -term_ext : term_ext;
    term_s_d = err_d_neg ? -term_ext : term_ext;

    tau_sum = tau_r + term_r;
    tau_dir = cfg.direction ? -tau_sum : tau_sum;
    tau_neg = tau_r[TAU_W-1];
    tau_abs = tau_neg ? unsigned'(-tau_r) : unsigned'(tau_r);

    // Current magnitude truncates toward zero and clamps at the limit.
    cm_full = mul_prod >> CUR_SHIFT;
    cm      = (cm_full > MUL_P_W'(CUR_LIMIT)) ? CUR_LIMIT : cm_full[CUR_MAG_W-1:0];
    cur_nxt = tau_neg ? -signed'(CUR_CMD_W'(cm)) : signed'(CUR_CMD_W'(cm));

    // Final stage of a reply: offset (position only), saturation, then the direction sign,
    // which saturates again since the most negative value has no opposite.
    fin_d = (job_r == JOB_POS) ? (sv_r - SV_W'(cfg.zero_offset)) : sv_r;
    fin_x = sat32(fin_d);
    if (!cfg.direction) begin
      fin_y = fin_x;
    end else if (fin_x == A_MIN) begin
      fin_y = A_MAX;
    end else begin
      fin_y = -fin_x;
    end

    fault_nxt = (joint_angle_r < cfg.angle_min) || (joint_angle_r > cfg.angle_max);
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = (job_sel == JOB_NONE) ? ST_IDLE : ST_MUL1;
      end
      ST_MUL1: begin
        if (mul_sts.done) begin
          state_nxt = ST_ARM2;
        end
      end
      ST_ARM2: begin
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        if (mul_sts.done) begin
          state_nxt = (job_r == JOB_TICK) ? ST_SUM : ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      ST_SUM: begin
        state_nxt = ST_ARM3;
      end
      ST_ARM3: begin
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        if (mul_sts.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs and multiplier operands.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_DISPATCH: begin
        mul_start = (job_sel != JOB_NONE);
        case (job_sel)
          JOB_SPEED: begin
            mul_a = MUL_A_W'(spd_mag);
            mul_b = MUL_B_W'(cfg.gear_recip);
          end
          JOB_POS: begin
            mul_a = MUL_A_W'(pos_mag);
            mul_b = MUL_B_W'(cfg.gear_recip);
          end
          JOB_TICK: begin
            mul_a = MUL_A_W'(err_a_mag);
            mul_b = cap_gp_r;
          end
          default: begin
          end
        endcase
      end
      ST_ARM2: begin
        mul_start = 1'b1;
        case (job_r)
          JOB_SPEED: begin
            mul_a = p1_r;
            mul_b = DEG_RAD_Q32;
          end
          JOB_POS: begin
            mul_a = p1_r;
            mul_b = CDEG_RAD_Q40;
          end
          default: begin
            mul_a = MUL_A_W'(err_d_mag);
            mul_b = cap_gd_r;
          end
        endcase
      end
      ST_ARM3: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(tau_abs);
        mul_b     = MUL_B_W'(cfg.current_scale);
      end
      ST_EMIT: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  assign in_take = in_ch.valid && in_ready;

  // ---------------------------------------------------------------------------
  // Control state and joint state.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      job_r         <= JOB_NONE;
      out_valid_r   <= 1'b0;
      joint_angle_r <= '0;
      joint_speed_r <= '0;
      rep_cur_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DISPATCH) begin
        job_r <= job_sel;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FINISH) begin
        if (job_r == JOB_SPEED) begin
          joint_speed_r <= fin_y;
          rep_cur_r     <= cap_pl_r[31:16];
        end else begin
          joint_angle_r <= fin_y;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      cap_cmd_r <= in_ch.command;
      cap_id_r  <= in_ch.rx_id;
      cap_pl_r  <= in_ch.rx_payload;
      cap_ff_r  <= in_ch.torque_ff;
      cap_gp_r  <= in_ch.gain_p;
      cap_gd_r  <= in_ch.gain_d;
      cap_at_r  <= in_ch.angle_target;
      cap_st_r  <= in_ch.speed_target;
    end
    if ((state_r == ST_MUL1) && mul_sts.done) begin
      p1_r  <= mul_prod[MUL_A_W-1:0];
      tau_r <= TAU_W'(cap_ff_r) + term_s_a;
    end
    if ((state_r == ST_MUL2) && mul_sts.done) begin
      sv_r   <= sv_nxt;
      term_r <= term_s_d;
    end
    if (state_r == ST_SUM) begin
      tau_r <= tau_dir;
    end
    if ((state_r == ST_MUL3) && mul_sts.done) begin
      cur_r <= cur_nxt;
    end
    if (out_load) begin
      tx_id_r      <= cfg.motor_id;
      tx_payload_r <= {16'h0000, MCUR_W'(cur_r), 24'h000000, OP_TORQUE};
      cur_cmd_r    <= cur_r;
      fault_r      <= fault_nxt;
      angle_now_r  <= joint_angle_r;
      meas_cur_r   <= rep_cur_r;
    end
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.tx_id            = tx_id_r;
  assign out_ch.tx_payload       = tx_payload_r;
  assign out_ch.current_command  = cur_cmd_r;
  assign out_ch.limit_fault      = fault_r;
  assign out_ch.angle_now        = angle_now_r;
  assign out_ch.measured_current = meas_cur_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_sts.busy)
    else $error("multiplier started while still running");

  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((cur_cmd_r >= -13'sd2048) && (cur_cmd_r <= 13'sd2048)))
    else $error("current command beyond its saturation limit");

  a_angle_written_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (joint_angle_r != $past(joint_angle_r)))
      |-> ($past(state_r) == ST_FINISH))
    else $error("joint angle changed outside the reply finish step");

  a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && !out_valid_r) |=> out_valid_r)
    else $error("finished tick did not reach the free output register");

endmodule
